// ----- sv/rational_arithmetic_unit_macros.svh -----
// Assertion macros for the rational arithmetic unit checker.
// Used by rau_checker.sv only.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
// implication checked every clock outside reset
`define RAU_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rau assertion failed");
// next-cycle implication
`define RAU_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rau assertion failed");
`endif

// ----- sv/rau_pkg.sv -----
// Package for the rational arithmetic unit: operation codes and word types.
// No dependencies.
`timescale 1ns / 1ps
package rau_pkg;
    localparam int WordW = 64;
    typedef logic [WordW-1:0] t_word;
    typedef logic [1:0] t_op;
    localparam t_op OP_ADD = 2'd0;
    localparam t_op OP_SUB = 2'd1;
    localparam t_op OP_MUL = 2'd2;
    localparam t_op OP_DIV = 2'd3;
    // divider control
    typedef struct packed {
        logic start;
        logic want_rem;
    } t_div_ctl;
endpackage

// ----- sv/rau_divider.sv -----
// Signed truncating 64-bit divider, one quotient bit per cycle.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rau_pkg::t_div_ctl i_ctl,
    input  rau_pkg::t_word    i_x,
    input  rau_pkg::t_word    i_y,
    output logic              o_done,
    output rau_pkg::t_word    o_result
);
    import rau_pkg::*;
    logic          r_busy, n_busy;
    logic [6:0]    r_cnt, n_cnt;
    t_word         r_q, n_q, r_r, n_r, r_d, n_d;
    logic          r_qneg, n_qneg, r_rneg, n_rneg, r_wrem, n_wrem;
    logic          r_done, n_done;
    t_word         r_res, n_res;
    logic [WordW:0] sh, diff;

    always_comb begin
        n_busy = r_busy; n_cnt = r_cnt; n_q = r_q; n_r = r_r; n_d = r_d;
        n_qneg = r_qneg; n_rneg = r_rneg; n_wrem = r_wrem; n_done = 1'b0;
        n_res = r_res;
        sh = {r_r, r_q[WordW-1]};
        diff = sh - {1'b0, r_d};
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt = 7'd0;
            n_q = i_x[WordW-1] ? (~i_x + 1'b1) : i_x;
            n_d = i_y[WordW-1] ? (~i_y + 1'b1) : i_y;
            n_r = '0;
            n_qneg = i_x[WordW-1] ^ i_y[WordW-1];
            n_rneg = i_x[WordW-1];
            n_wrem = i_ctl.want_rem;
        end else if (r_busy) begin
            if (!diff[WordW]) begin
                n_r = diff[WordW-1:0];
                n_q = {r_q[WordW-2:0], 1'b1};
            end else begin
                n_r = sh[WordW-1:0];
                n_q = {r_q[WordW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'(WordW-1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                if (r_wrem) n_res = r_rneg ? (~n_r + 1'b1) : n_r;
                else        n_res = r_qneg ? (~n_q + 1'b1) : n_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
        r_cnt <= n_cnt; r_q <= n_q; r_r <= n_r; r_d <= n_d;
        r_qneg <= n_qneg; r_rneg <= n_rneg; r_wrem <= n_wrem; r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_result = r_res;
endmodule

// ----- sv/rational_arithmetic_unit.sv -----
// Rational arithmetic unit: combines two signed fractions and reduces the result
// by a Euclid divisor. Uses a single shared 64-bit bit-serial divider.
// Channels: input beat (i_valid/o_stall) carries op and four operands; output
//   beat (o_valid/i_stall) carries res_num, res_den, status.
// The block takes one item at a time; o_stall is high from acceptance until
//   the result beat has been taken.
// Sequence: products are formed in S_M0 to S_M2 and combined in S_M3, S_SUM
//   loads the Euclid operands, then one divider run per Euclid step (up to
//   about 93 steps for 64-bit values) and two runs for the final quotients;
//   all paced by the bit-serial divider.
// A 32x32 multiplier is shared over states S_M0 to S_M2 for the cross products.
// Reset (synchronous, active low) drops the output valid and returns to idle.
// While the receiver stalls, the result holds and no new item is taken.
`timescale 1ns / 1ps
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic signed [31:0] i_a_num,
    input  logic signed [31:0] i_a_den,
    input  logic signed [31:0] i_b_num,
    input  logic signed [31:0] i_b_den,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [63:0] o_res_num,
    output logic signed [63:0] o_res_den,
    output logic        o_status
);
    import rau_pkg::*;
    localparam logic [3:0] S_IDLE = 4'd0, S_M0 = 4'd1, S_M1 = 4'd2, S_M2 = 4'd3,
                           S_M3 = 4'd4, S_SUM = 4'd5, S_EUC = 4'd6, S_EWT = 4'd7,
                           S_QN = 4'd8, S_QNW = 4'd9, S_QD = 4'd10, S_QDW = 4'd11,
                           S_OUT = 4'd12;
    logic [3:0] r_st, n_st;
    t_op   r_op;
    logic signed [31:0] r_an, r_ad, r_bn, r_bd;
    t_word r_p0, r_p1, r_n, r_d, r_x, r_y, r_g;
    t_word r_rn, r_rd;
    logic  r_stat;
    logic signed [31:0] ma, mb;
    t_word prod;
    t_div_ctl dctl;
    t_word dx, dy, dres;
    logic  ddone;

    function automatic logic signed [31:0] sx(input logic [31:0] v);
        logic [OPERAND_WIDTH-1:0] t;
        t = v[OPERAND_WIDTH-1:0];
        return 32'(signed'(t));
    endfunction

    rau_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(dctl), .i_x(dx),
                       .i_y(dy), .o_done(ddone), .o_result(dres));

    always_comb begin
        ma = r_an; mb = r_bd;
        unique case (r_st)
            S_M0: begin ma = r_an; mb = (r_op == OP_MUL) ? r_bn : r_bd; end
            S_M1: begin ma = r_bn; mb = r_ad; end
            S_M2: begin ma = r_ad; mb = (r_op == OP_DIV) ? r_bn : r_bd; end
            default: ;
        endcase
    end
    assign prod = 64'(64'(signed'(ma)) * 64'(signed'(mb)));

    always_comb begin
        dctl = '0; dx = r_x; dy = r_y;
        unique case (r_st)
            S_EUC: begin dctl.start = 1'b1; dctl.want_rem = 1'b1; end
            S_QN:  begin dctl.start = 1'b1; dx = r_n; dy = r_g; end
            S_QD:  begin dctl.start = 1'b1; dx = r_d; dy = r_g; end
            default: ;
        endcase
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (i_valid) n_st = S_M0;
            S_M0: n_st = S_M1;
            S_M1: n_st = S_M2;
            S_M2: n_st = S_M3;
            S_M3: n_st = S_SUM;
            S_SUM: n_st = S_EUC;
            S_EUC: begin
                if (r_n == '0 || r_y == '0) n_st = (r_g == '0) ? S_OUT : S_QN;
                else n_st = S_EWT;
            end
            S_EWT: if (ddone) n_st = S_EUC;
            S_QN: n_st = S_QNW;
            S_QNW: if (ddone) n_st = S_QD;
            S_QD: n_st = S_QDW;
            S_QDW: if (ddone) n_st = S_OUT;
            S_OUT: if (!i_stall) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= S_IDLE;
        else          r_st <= n_st;
        unique case (r_st)
            S_IDLE: begin
                r_op <= i_req_type;
                r_an <= sx(i_a_num); r_ad <= sx(i_a_den);
                r_bn <= sx(i_b_num); r_bd <= sx(i_b_den);
            end
            S_M0: r_p0 <= prod;
            S_M1: r_p1 <= prod;
            S_M2: r_d <= prod;
            S_M3: begin
                if (r_op == OP_ADD)      r_n <= r_p0 + r_p1;
                else if (r_op == OP_SUB) r_n <= r_p0 - r_p1;
                else                     r_n <= r_p0;
            end
            S_SUM: begin
                r_x <= r_n; r_y <= r_d;
                // zero numerator: divisor is the denominator itself
                r_g <= (r_n == '0) ? r_d : r_n;
            end
            S_EUC: if (r_y != '0 && r_n != '0) r_g <= r_y;
            S_EWT: if (ddone) begin r_x <= r_y; r_y <= dres; end
            S_QNW: if (ddone) r_rn <= dres;
            S_QDW: if (ddone) r_rd <= dres;
            default: ;
        endcase
        if (r_st == S_EUC && (r_n == '0 || r_y == '0)) begin
            r_stat <= (r_g == '0);
            if (r_g == '0) begin r_rn <= '0; r_rd <= '0; end
        end
    end

    assign o_stall = (r_st != S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_res_num = r_rn;
    assign o_res_den = r_rd;
    assign o_status = r_stat;
endmodule

// ----- sv/rau_checker.sv -----
// Port-level checker for rational_arithmetic_unit, bound to the top level.
// Depends on rational_arithmetic_unit_macros.svh.
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_macros.svh"
module rau_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_res_num,
    input logic [63:0] o_res_den,
    input logic        o_status
);
    `RAU_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_res_num))
    `RAU_ASSERT_IMP(a_busy, i_clk, i_rst_n, o_valid, o_stall)
    `RAU_ASSERT_IMP(a_zero, i_clk, i_rst_n, o_valid && o_status, o_res_num == 64'd0 && o_res_den == 64'd0)
    `RAU_ASSERT_NXT(a_take, i_clk, i_rst_n, i_valid && !o_stall, o_stall && !o_valid)
endmodule

bind rational_arithmetic_unit rau_checker u_chk (.*);
